// ----- hw/rtl/tgq_pkg.sv -----
// Package for the team queue: field widths, command and status codes,
// parameter defaults and the member map request type.
// No dependencies.
`default_nettype none

package tgq_pkg;

  localparam int PERSON_ID_W = 10;
  localparam int TEAM_ID_W   = 4;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  localparam int DEF_TEAMS      = 16;
  localparam int DEF_PERSON_IDS = 1024;
  localparam int DEF_TEAM_DEPTH = 64;

  localparam logic [CMD_W-1:0] CMD_ASSIGN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                   write;
    logic [PERSON_ID_W-1:0] person;
    logic [TEAM_ID_W-1:0]   team;
  } map_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tgq_member_map.sv -----
// Person to team map held in a synchronous memory, with the clearing sweep
// that sets every entry to team zero after reset.
// Depends on tgq_pkg.
`default_nettype none

module tgq_member_map import tgq_pkg::*; #(
  parameter int TEAMS      = DEF_TEAMS,
  parameter int PERSON_IDS = DEF_PERSON_IDS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire map_req_t       req,
  output logic [(((TEAMS < (2 ** TEAM_ID_W)) ? TEAMS : (2 ** TEAM_ID_W)) > 1 ?
                 $clog2((TEAMS < (2 ** TEAM_ID_W)) ? TEAMS : (2 ** TEAM_ID_W)) : 1) - 1:0]
                              map_team,
  output logic                clearing
);

  localparam int TEAMS_USED = (TEAMS < (2 ** TEAM_ID_W)) ? TEAMS : (2 ** TEAM_ID_W);
  localparam int TW         = (TEAMS_USED > 1) ? $clog2(TEAMS_USED) : 1;
  localparam int MAP_DEPTH  = (PERSON_IDS < (2 ** PERSON_ID_W)) ? PERSON_IDS
                                                                : (2 ** PERSON_ID_W);
  localparam int MW         = $clog2(MAP_DEPTH);

  // Remainder by the map depth through conditional subtraction of shifted
  // copies of the depth; steps that cannot apply are removed at elaboration.
  function automatic logic [PERSON_ID_W-1:0] person_slot(
    input logic [PERSON_ID_W-1:0] value
  );
    logic [PERSON_ID_W-1:0] rem;
    rem = value;
    for (int k = PERSON_ID_W - 1; k >= 0; k--) begin
      if ((MAP_DEPTH << k) < (1 << PERSON_ID_W)) begin
        if (rem >= PERSON_ID_W'(MAP_DEPTH << k)) begin
          rem = rem - PERSON_ID_W'(MAP_DEPTH << k);
        end
      end
    end
    return rem;
  endfunction

  logic [TW-1:0]            mem [MAP_DEPTH];
  logic [MW-1:0]            clear_idx;
  logic [PERSON_ID_W-1:0]   slot_full;
  logic [MW-1:0]            slot;

  assign slot_full = person_slot(req.person);
  assign slot      = slot_full[MW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      if (clear_idx == MW'(MAP_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clear_idx <= clear_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_idx] <= '0;
    end else if (req.write) begin
      mem[slot] <= req.team[TW-1:0];
    end
    map_team <= mem[slot];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/team_grouped_fifo_queue_unit.sv -----
// Top level of the team queue: command sequencing, team FIFO storage in a
// synchronous memory, per-team head and count, and the order ring of teams.
// Depends on tgq_pkg and tgq_member_map.
//
//   Channel   Handshake                 Signals
//   command   start while busy is low   cmd, person_id, team_id
//   result    done for one cycle        status, person_out, team_out
//
// For every command, the transfer cycle reads the member map and the head
// slot of the leading team, and the next cycle updates the team FIFO, the
// counts and the ring. The result appears the cycle after.
// After reset the block stays busy while the member map memory (at most 1024
// entries) is swept to team zero. Results cannot be held off, so nothing on
// the result side stalls the block.
`default_nettype none

module team_grouped_fifo_queue_unit import tgq_pkg::*; #(
  parameter int TEAMS      = DEF_TEAMS,
  parameter int PERSON_IDS = DEF_PERSON_IDS,
  parameter int TEAM_DEPTH = DEF_TEAM_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [CMD_W-1:0]       cmd,
  input  wire logic [PERSON_ID_W-1:0] person_id,
  input  wire logic [TEAM_ID_W-1:0]   team_id,
  output logic                        done,
  output logic [STATUS_W-1:0]         status,
  output logic [PERSON_ID_W-1:0]      person_out,
  output logic [TEAM_ID_W-1:0]        team_out
);

  localparam int TEAMS_USED = (TEAMS < (2 ** TEAM_ID_W)) ? TEAMS : (2 ** TEAM_ID_W);
  localparam int TW         = (TEAMS_USED > 1) ? $clog2(TEAMS_USED) : 1;
  localparam int OCW        = $clog2(TEAMS_USED + 1);
  localparam int DW         = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
  localparam int CW         = $clog2(TEAM_DEPTH + 1);
  localparam int SLOT_AW    = TW + DW;
  localparam int SLOT_DEPTH = 2 ** SLOT_AW;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]             state;
  logic [CMD_W-1:0]       cmd_q;
  logic [PERSON_ID_W-1:0] pid_q;

  logic [DW-1:0]          team_head  [TEAMS_USED];
  logic [CW-1:0]          team_count [TEAMS_USED];
  logic [TW-1:0]          ring       [TEAMS_USED];
  logic [TW-1:0]          order_head;
  logic [OCW-1:0]         order_count;

  logic [PERSON_ID_W-1:0] slots [SLOT_DEPTH];
  logic [PERSON_ID_W-1:0] slot_rd;

  logic                   accept;
  map_req_t               map_req;
  logic [TW-1:0]          map_team;
  logic                   map_clearing;

  logic [TW-1:0]          deq_team;
  logic [TW-1:0]          sel_team;
  logic [DW-1:0]          sel_head;
  logic [CW-1:0]          sel_count;
  logic                   team_full;
  logic [CW:0]            slot_sum;
  logic [CW:0]            slot_wrap;
  logic [DW-1:0]          slot_idx;
  logic [DW-1:0]          head_inc;
  logic [OCW:0]           tail_sum;
  logic [OCW:0]           tail_wrap;
  logic [TW-1:0]          ring_tail;
  logic [TW-1:0]          order_head_inc;
  logic                   slot_we;
  logic [SLOT_AW-1:0]     slot_ra;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  assign map_req.write  = accept && (cmd == CMD_ASSIGN) && (32'(team_id) < TEAMS);
  assign map_req.person = person_id;
  assign map_req.team   = team_id;

  tgq_member_map #(
    .TEAMS      (TEAMS),
    .PERSON_IDS (PERSON_IDS)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .req      (map_req),
    .map_team (map_team),
    .clearing (map_clearing)
  );

  assign deq_team  = ring[order_head];
  assign slot_ra   = {deq_team, team_head[deq_team]};

  assign sel_team  = (cmd_q == CMD_ENQUEUE) ? map_team : deq_team;
  assign sel_head  = team_head[sel_team];
  assign sel_count = team_count[sel_team];
  assign team_full = (sel_count >= CW'(TEAM_DEPTH));

  assign slot_sum  = (CW + 1)'(sel_head) + (CW + 1)'(sel_count);
  assign slot_wrap = (slot_sum >= (CW + 1)'(TEAM_DEPTH)) ?
                     slot_sum - (CW + 1)'(TEAM_DEPTH) : slot_sum;
  assign slot_idx  = slot_wrap[DW-1:0];
  assign head_inc  = (sel_head == DW'(TEAM_DEPTH - 1)) ? '0 : sel_head + 1'b1;

  assign tail_sum  = (OCW + 1)'(order_head) + (OCW + 1)'(order_count);
  assign tail_wrap = (tail_sum >= (OCW + 1)'(TEAMS_USED)) ?
                     tail_sum - (OCW + 1)'(TEAMS_USED) : tail_sum;
  assign ring_tail = tail_wrap[TW-1:0];
  assign order_head_inc = (order_head == TW'(TEAMS_USED - 1)) ? '0 : order_head + 1'b1;

  assign slot_we = (state == S_EXEC) && (cmd_q == CMD_ENQUEUE) && !team_full;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slots[{sel_team, slot_idx}] <= pid_q;
    end
    if (accept) begin
      slot_rd <= slots[slot_ra];
      cmd_q   <= cmd;
      pid_q   <= person_id;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we && (sel_count == '0) && (order_count < OCW'(TEAMS_USED))) begin
      ring[ring_tail] <= sel_team;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      done        <= 1'b0;
      order_head  <= '0;
      order_count <= '0;
      for (int i = 0; i < TEAMS_USED; i++) begin
        team_head[i]  <= '0;
        team_count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (!map_clearing) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          status     <= STATUS_OK;
          person_out <= '0;
          team_out   <= '0;
          case (cmd_q)
            CMD_ENQUEUE: begin
              if (team_full) begin
                status <= STATUS_FULL;
              end else begin
                team_count[sel_team] <= sel_count + 1'b1;
                if ((sel_count == '0) && (order_count < OCW'(TEAMS_USED))) begin
                  order_count <= order_count + 1'b1;
                end
              end
            end
            CMD_DEQUEUE: begin
              if ((order_count == '0) || (sel_count == '0)) begin
                status <= STATUS_EMPTY;
              end else begin
                person_out           <= slot_rd;
                team_out             <= TEAM_ID_W'(sel_team);
                team_head[sel_team]  <= head_inc;
                team_count[sel_team] <= sel_count - 1'b1;
                if (sel_count == CW'(1)) begin
                  order_head  <= order_head_inc;
                  order_count <= order_count - 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              order_head  <= '0;
              order_count <= '0;
              for (int i = 0; i < TEAMS_USED; i++) begin
                team_head[i]  <= '0;
                team_count[i] <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/team_queue_checker.sv -----
// Result checker for the team queue: watches the command and result transfers,
// predicts each result from its own copy of the map, team FIFOs and order ring.
// Depends on tgq_pkg.
`timescale 1ns / 1ps

module team_queue_checker import tgq_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   busy,
  input  wire logic [CMD_W-1:0]       cmd,
  input  wire logic [PERSON_ID_W-1:0] person_id,
  input  wire logic [TEAM_ID_W-1:0]   team_id,
  input  wire logic                   done,
  input  wire logic [STATUS_W-1:0]    status,
  input  wire logic [PERSON_ID_W-1:0] person_out,
  input  wire logic [TEAM_ID_W-1:0]   team_out,
  output int                          fail_count,
  output int                          outcomes_due,
  output int                          outcomes_checked,
  output int                          empty_dequeues,
  output int                          full_drops
);

  localparam int TEAMS      = DEF_TEAMS;
  localparam int PERSON_IDS = DEF_PERSON_IDS;
  localparam int TEAM_DEPTH = DEF_TEAM_DEPTH;
  localparam int SLOT_W     = $clog2(TEAM_DEPTH);
  localparam int RING_W     = $clog2(TEAMS);

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [PERSON_ID_W-1:0] person;
    logic [TEAM_ID_W-1:0]   team;
  } team_result_t;

  logic [TEAM_ID_W-1:0]   member_team [PERSON_IDS];
  logic [PERSON_ID_W-1:0] team_slots [TEAMS][TEAM_DEPTH];
  logic [SLOT_W-1:0]      team_head [TEAMS];
  logic [SLOT_W:0]        team_count [TEAMS];
  logic [TEAM_ID_W-1:0]   order_ring [TEAMS];
  logic [RING_W-1:0]      order_head;
  logic [RING_W:0]        order_count;

  team_result_t pending_outcomes [$];
  int errors = 0;
  int checked = 0;
  int empties = 0;
  int fulls = 0;

  function automatic void empty_all_queues();
    for (int i = 0; i < TEAMS; i++) begin
      team_head[i] = '0;
      team_count[i] = '0;
    end
    order_head = '0;
    order_count = '0;
  endfunction

  function automatic team_result_t serve_command(logic [CMD_W-1:0] c,
                                                 logic [PERSON_ID_W-1:0] p,
                                                 logic [TEAM_ID_W-1:0] t);
    team_result_t r;
    logic [TEAM_ID_W-1:0] tm;
    logic [SLOT_W-1:0] slot;
    logic [RING_W-1:0] tail;
    r = '{status: STATUS_OK, person: '0, team: '0};
    case (c)
      CMD_ASSIGN: begin
        member_team[p] = t;
      end
      CMD_ENQUEUE: begin
        tm = member_team[p];
        if (team_count[tm] >= TEAM_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          slot = team_head[tm] + team_count[tm][SLOT_W-1:0];
          if (team_count[tm] == 0 && order_count < TEAMS) begin
            tail = order_head + order_count[RING_W-1:0];
            order_ring[tail] = tm;
            order_count = order_count + 1'b1;
          end
          team_slots[tm][slot] = p;
          team_count[tm] = team_count[tm] + 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        if (order_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          tm = order_ring[order_head];
          if (team_count[tm] == 0) begin
            r.status = STATUS_EMPTY;
          end else begin
            slot = team_head[tm];
            r.person = team_slots[tm][slot];
            r.team = tm;
            team_head[tm] = slot + 1'b1;
            team_count[tm] = team_count[tm] - 1'b1;
            if (team_count[tm] == 0) begin
              order_head = order_head + 1'b1;
              order_count = order_count - 1'b1;
            end
          end
        end
      end
      CMD_CLEAR: begin
        empty_all_queues();
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    team_result_t want;
    if (rst) begin
      for (int i = 0; i < PERSON_IDS; i++) member_team[i] = '0;
      empty_all_queues();
      pending_outcomes.delete();
    end else begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with none expected: status %0d person %0d team %0d",
                   $time, status, person_out, team_out);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          checked++;
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
          if (person_out !== want.person) begin
            $display("%0t: person_out expected %0d actual %0d",
                     $time, want.person, person_out);
            errors++;
          end
          if (team_out !== want.team) begin
            $display("%0t: team_out expected %0d actual %0d", $time, want.team, team_out);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        want = serve_command(cmd, person_id, team_id);
        if (want.status == STATUS_EMPTY) empties++;
        if (want.status == STATUS_FULL) fulls++;
        pending_outcomes.push_back(want);
      end
    end
    fail_count <= errors;
    outcomes_due <= pending_outcomes.size();
    outcomes_checked <= checked;
    empty_dequeues <= empties;
    full_drops <= fulls;
  end

endmodule

// ----- tb/sv/team_grouped_fifo_queue_unit_tb.sv -----
// Testbench top for the team queue: drives directed and random command
// transfers with random gaps and gives the verdict from the checker's count.
// Depends on tgq_pkg, team_grouped_fifo_queue_unit and team_queue_checker.
`timescale 1ns / 1ps

module team_grouped_fifo_queue_unit_tb import tgq_pkg::*;;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 10;

  typedef enum int {MIX, FILL, DRAIN, CHURN} traffic_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CMD_W-1:0] cmd = CMD_ASSIGN;
  logic [PERSON_ID_W-1:0] person_id = '0;
  logic [TEAM_ID_W-1:0] team_id = '0;
  logic busy;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [PERSON_ID_W-1:0] person_out;
  logic [TEAM_ID_W-1:0] team_out;

  int fail_count;
  int outcomes_due;
  int outcomes_checked;
  int empty_dequeues;
  int full_drops;
  int cycle_count = 0;
  int commands_sent = 0;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  team_grouped_fifo_queue_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .person_id(person_id), .team_id(team_id),
    .done(done), .status(status), .person_out(person_out), .team_out(team_out)
  );

  team_queue_checker results_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .person_id(person_id), .team_id(team_id),
    .done(done), .status(status), .person_out(person_out), .team_out(team_out),
    .fail_count(fail_count), .outcomes_due(outcomes_due),
    .outcomes_checked(outcomes_checked), .empty_dequeues(empty_dequeues),
    .full_drops(full_drops)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PERSON_ID_W-1:0] pick_person();
    if ($urandom_range(0, 3) == 0) return PERSON_ID_W'($urandom);
    return {($urandom_range(0, 1) ? 5'h1F : 5'h00), 5'($urandom)};
  endfunction

  // Called at a rising edge; returns at the edge that completes the transfer,
  // or after the idle gap that follows it.
  task automatic issue(input logic [CMD_W-1:0] c, input logic [PERSON_ID_W-1:0] p,
                       input logic [TEAM_ID_W-1:0] t);
    int gap;
    gap = pick_gap();
    start <= 1'b1;
    cmd <= c;
    person_id <= p;
    team_id <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    commands_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      cmd <= CMD_W'($urandom);
      person_id <= PERSON_ID_W'($urandom);
      team_id <= TEAM_ID_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    traffic_mode_t mode;
    int sent;
    int phase;
    int span;
    int r;
    logic [PERSON_ID_W-1:0] focus;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_ENQUEUE, 10'd0, 4'd0);
    issue(CMD_ASSIGN, 10'd1023, 4'd15);
    issue(CMD_ENQUEUE, 10'd1023, 4'd0);
    issue(CMD_ENQUEUE, 10'd5, 4'd15);
    issue(CMD_ASSIGN, 10'd7, 4'd3);
    issue(CMD_ENQUEUE, 10'd7, 4'd0);
    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_ENQUEUE, 10'd7, 4'd0);
    issue(CMD_ASSIGN, 10'd7, 4'd9);
    issue(CMD_ENQUEUE, 10'd7, 4'd0);
    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_ENQUEUE, 10'd1023, 4'd0);
    issue(CMD_ENQUEUE, 10'd682, 4'd0);
    issue(CMD_CLEAR, 10'd0, 4'd0);
    issue(CMD_DEQUEUE, 10'd0, 4'd0);
    issue(CMD_ASSIGN, 10'd682, 4'd10);
    issue(CMD_ENQUEUE, 10'd341, 4'd5);
    issue(CMD_ENQUEUE, 10'd682, 4'd10);
    issue(CMD_DEQUEUE, 10'd1023, 4'd15);

    // Phases of biased traffic; the first one overfills a single team FIFO.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = (phase == 0) ? FILL : traffic_mode_t'($urandom_range(0, 3));
      quiet = ($urandom_range(0, 3) == 0);
      span = (mode == FILL) ? $urandom_range(70, 90) : $urandom_range(40, 90);
      focus = pick_person();
      if (mode == FILL) begin
        issue(CMD_ASSIGN, focus, TEAM_ID_W'($urandom));
        sent++;
      end
      for (int i = 0; i < span; i++) begin
        r = $urandom_range(0, 99);
        case (mode)
          FILL:
            if (r < 90 || phase == 0) issue(CMD_ENQUEUE, focus, TEAM_ID_W'($urandom));
            else issue(CMD_DEQUEUE, pick_person(), TEAM_ID_W'($urandom));
          DRAIN:
            if (r < 5) issue(CMD_ASSIGN, pick_person(), TEAM_ID_W'($urandom));
            else if (r < 35) issue(CMD_ENQUEUE, pick_person(), TEAM_ID_W'($urandom));
            else issue(CMD_DEQUEUE, pick_person(), TEAM_ID_W'($urandom));
          CHURN:
            if (r < 40) issue(CMD_ASSIGN, pick_person(), TEAM_ID_W'($urandom));
            else if (r < 75) issue(CMD_ENQUEUE, pick_person(), TEAM_ID_W'($urandom));
            else issue(CMD_DEQUEUE, pick_person(), TEAM_ID_W'($urandom));
          default:
            if (r < 20) issue(CMD_ASSIGN, pick_person(), TEAM_ID_W'($urandom));
            else if (r < 65) issue(CMD_ENQUEUE, pick_person(), TEAM_ID_W'($urandom));
            else if (r < 98) issue(CMD_DEQUEUE, pick_person(), TEAM_ID_W'($urandom));
            else issue(CMD_CLEAR, pick_person(), TEAM_ID_W'($urandom));
        endcase
        sent++;
      end
      phase++;
    end

    quiet = 1'b0;
    start <= 1'b0;
    @(posedge clk);
    while (outcomes_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d commands in %0d random phases after the directed sequence.",
             commands_sent, phase);
    $display("Checked %0d results, %0d empty dequeues and %0d full-FIFO drops among them.",
             outcomes_checked, empty_dequeues, full_drops);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tgq_pkg.sv
hw/rtl/tgq_member_map.sv
hw/rtl/team_grouped_fifo_queue_unit.sv
tb/sv/team_queue_checker.sv
tb/sv/team_grouped_fifo_queue_unit_tb.sv
